// ===== design/artl_pkg.sv =====
// Shared types, constants and the millivolt threshold table for the
// ADC ratio temperature lookup block. No dependencies.
`default_nettype none

package artl_pkg;

   // Sample and arithmetic widths.
   localparam int ADC_BITS  = 12;
   localparam int REF_W     = 12;
   localparam int COUNT_W   = 4;
   localparam int SUM_W     = 15;
   localparam int PROD_W    = REF_W + SUM_W;
   localparam int MV_W      = 16;
   localparam int TEMP_W    = 9;

   localparam int MAX_PAIRS = 8;
   localparam int MV_MAX    = 65535;

   // Temperature table: one millivolt threshold per step.
   localparam int TABLE_ENTRIES = 33;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int T_LOW         = -30;
   localparam int T_STEP        = 5;

   // Configuration register map and reset values.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = REF_W;
   localparam logic [CSR_INDEX_W-1:0] REG_REFERENCE_MV  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_AVERAGE_COUNT = CSR_INDEX_W'(1);
   localparam logic [REF_W-1:0]   REFERENCE_MV_RESET  = REF_W'(1200);
   localparam logic [COUNT_W-1:0] AVERAGE_COUNT_RESET = COUNT_W'(5);

   typedef logic [MV_W-1:0]          mv_type;
   typedef logic signed [TEMP_W-1:0] temp_type;

   localparam mv_type MV_ROM [TABLE_ENTRIES] = '{
      16'd721,  16'd733,  16'd746,  16'd759,  16'd772,  16'd786,  16'd805,  16'd820,
      16'd834,  16'd848,  16'd865,  16'd873,  16'd889,  16'd902,  16'd914,  16'd924,
      16'd947,  16'd956,  16'd965,  16'd993,  16'd1000, 16'd1012, 16'd1027, 16'd1042,
      16'd1057, 16'd1070, 16'd1085, 16'd1094, 16'd1118, 16'd1132, 16'd1144, 16'd1162,
      16'd1180
   };

endpackage

`default_nettype wire

// ===== design/adc_ratio_temperature_lookup_top.sv =====
// Top level of the averaged ratiometric ADC temperature lookup.
// Depends on artl_pkg for widths, register map and the threshold table.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    req_sensor_sample, req_reference_sample
//   rsp      rsp_valid/rsp_ready    rsp_temperature_c, rsp_sensor_mv, rsp_reference_zero
//   csr      csr_valid/csr_ready    csr_index, csr_data
//
// A beat that does not complete a batch is accumulated, and req_ready stays high.
// The beat that completes a batch runs through one shared restoring divider
// (15 steps per sum average, 27 steps for the millivolt quotient) plus a multiply,
// then a table scan, an optional pick and the output load. A zero reference
// average skips the multiply, quotient, scan and pick. A stalled rsp holds the block
// only before it loads the next result. Synchronous reset clears the control state.
`default_nettype none

module adc_ratio_temperature_lookup_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [artl_pkg::ADC_BITS-1:0]       req_sensor_sample,
   input  logic [artl_pkg::ADC_BITS-1:0]       req_reference_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output artl_pkg::temp_type                  rsp_temperature_c,
   output artl_pkg::mv_type                    rsp_sensor_mv,
   output logic                                rsp_reference_zero,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [artl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [artl_pkg::CSR_DATA_W-1:0]     csr_data
);
   import artl_pkg::*;

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] ST_DIV_S  = 3'd1;
   localparam logic [STATE_W-1:0] ST_DIV_R  = 3'd2;
   localparam logic [STATE_W-1:0] ST_MUL    = 3'd3;
   localparam logic [STATE_W-1:0] ST_DIV_MV = 3'd4;
   localparam logic [STATE_W-1:0] ST_SCAN   = 3'd5;
   localparam logic [STATE_W-1:0] ST_PICK   = 3'd6;
   localparam logic [STATE_W-1:0] ST_EMIT   = 3'd7;

   localparam int STEP_W = $clog2(PROD_W + 1);
   localparam logic [STEP_W-1:0] SUM_STEPS = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] MV_STEPS  = STEP_W'(PROD_W);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam temp_type TEMP_LOW  = TEMP_W'(T_LOW);
   localparam temp_type TEMP_STEP = TEMP_W'(T_STEP);

   logic [STATE_W-1:0] state_ff, state_in;
   logic [REF_W-1:0]   reference_mv_ff, reference_mv_in;
   logic [COUNT_W-1:0] average_count_ff, average_count_in;
   logic [SUM_W-1:0]   sensor_sum_ff, sensor_sum_in;
   logic [SUM_W-1:0]   reference_sum_ff, reference_sum_in;
   logic [COUNT_W-1:0] pair_count_ff, pair_count_in;
   logic [SUM_W-1:0]   sensor_avg_ff, sensor_avg_in;

   // Shared divider registers.
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]   divisor_ff, divisor_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // Table scan and result staging.
   logic [IDX_W-1:0]   idx_ff, idx_in;
   temp_type           temp_ff, temp_in;
   mv_type             mv_ff, mv_in;
   temp_type           res_temp_ff, res_temp_in;
   logic               res_zero_ff, res_zero_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   temp_type           rsp_temp_ff, rsp_temp_in;
   mv_type             rsp_mv_ff, rsp_mv_in;
   logic               rsp_zero_ff, rsp_zero_in;

   logic               req_fire;
   logic [COUNT_W-1:0] n_eff;
   logic [COUNT_W-1:0] pair_count_next;
   logic [SUM_W-1:0]   sensor_sum_next;
   logic [SUM_W-1:0]   reference_sum_next;
   logic [SUM_W:0]     partial;
   logic [SUM_W+1:0]   diff;
   logic               quo_bit;
   logic [SUM_W-1:0]   rem_step;
   logic [PROD_W-1:0]  quo_step;
   logic               last_step;
   mv_type             rom_hi;
   mv_type             rom_lo;
   mv_type             gap_lo;
   mv_type             gap_hi;

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temperature_c  = rsp_temp_ff;
   assign rsp_sensor_mv      = rsp_mv_ff;
   assign rsp_reference_zero = rsp_zero_ff;
   assign req_fire           = req_valid && req_ready;

   // Effective pair count: zero acts as one, above the maximum acts as the maximum.
   always_comb begin
      if (average_count_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (average_count_ff > COUNT_W'(MAX_PAIRS)) begin
         n_eff = COUNT_W'(MAX_PAIRS);
      end else begin
         n_eff = average_count_ff;
      end
   end

   assign sensor_sum_next    = sensor_sum_ff + SUM_W'(req_sensor_sample);
   assign reference_sum_next = reference_sum_ff + SUM_W'(req_reference_sample);
   assign pair_count_next    = pair_count_ff + COUNT_W'(1);

   // One restoring division step: shift in the next dividend bit, try to subtract.
   assign partial   = {rem_ff, quo_ff[PROD_W-1]};
   assign diff      = {1'b0, partial} - {2'b00, divisor_ff};
   assign quo_bit   = !diff[SUM_W+1];
   assign rem_step  = quo_bit ? diff[SUM_W-1:0] : partial[SUM_W-1:0];
   assign quo_step  = {quo_ff[PROD_W-2:0], quo_bit};
   assign last_step = (step_ff == STEP_W'(1));

   // Table reads for the scan compare and the nearest-step pick.
   assign rom_hi = MV_ROM[idx_ff];
   assign rom_lo = MV_ROM[idx_ff - IDX_W'(1)];
   assign gap_lo = mv_ff - rom_lo;
   assign gap_hi = rom_hi - mv_ff;

   // Sequencer and datapath next values.
   always_comb begin
      state_in         = state_ff;
      reference_mv_in  = reference_mv_ff;
      average_count_in = average_count_ff;
      sensor_sum_in    = sensor_sum_ff;
      reference_sum_in = reference_sum_ff;
      pair_count_in    = pair_count_ff;
      sensor_avg_in    = sensor_avg_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      divisor_in       = divisor_ff;
      step_in          = step_ff;
      idx_in           = idx_ff;
      temp_in          = temp_ff;
      mv_in            = mv_ff;
      res_temp_in      = res_temp_ff;
      res_zero_in      = res_zero_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_temp_in      = rsp_temp_ff;
      rsp_mv_in        = rsp_mv_ff;
      rsp_zero_in      = rsp_zero_ff;

      // The output beat leaves when the sink takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes; unknown indexes are ignored.
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_REFERENCE_MV) begin
            reference_mv_in = csr_data[REF_W-1:0];
         end else if (csr_index == REG_AVERAGE_COUNT) begin
            average_count_in = csr_data[COUNT_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sensor_sum_in    = sensor_sum_next;
               reference_sum_in = reference_sum_next;
               pair_count_in    = pair_count_next;
               if (pair_count_next >= n_eff) begin
                  // Batch complete: start the sensor average.
                  quo_in     = {sensor_sum_next, (PROD_W - SUM_W)'(0)};
                  rem_in     = '0;
                  divisor_in = SUM_W'(n_eff);
                  step_in    = SUM_STEPS;
                  state_in   = ST_DIV_S;
               end
            end
         end
         ST_DIV_S: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               sensor_avg_in = quo_step[SUM_W-1:0];
               quo_in        = {reference_sum_ff, (PROD_W - SUM_W)'(0)};
               rem_in        = '0;
               step_in       = SUM_STEPS;
               state_in      = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               sensor_sum_in    = '0;
               reference_sum_in = '0;
               pair_count_in    = '0;
               if (quo_step[SUM_W-1:0] == '0) begin
                  res_temp_in = '0;
                  res_zero_in = 1'b1;
                  mv_in       = '0;
                  state_in    = ST_EMIT;
               end else begin
                  divisor_in = quo_step[SUM_W-1:0];
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            quo_in   = PROD_W'(reference_mv_ff) * PROD_W'(sensor_avg_ff);
            rem_in   = '0;
            step_in  = MV_STEPS;
            state_in = ST_DIV_MV;
         end
         ST_DIV_MV: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (last_step) begin
               if (quo_step > PROD_W'(MV_MAX)) begin
                  mv_in = MV_W'(MV_MAX);
               end else begin
                  mv_in = quo_step[MV_W-1:0];
               end
               res_zero_in = 1'b0;
               idx_in      = '0;
               temp_in     = TEMP_LOW;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Walk the thresholds until the first one above the voltage.
            if (mv_ff < rom_hi) begin
               if (idx_ff == '0) begin
                  res_temp_in = TEMP_LOW;
                  state_in    = ST_EMIT;
               end else begin
                  state_in = ST_PICK;
               end
            end else if (idx_ff == LAST_IDX) begin
               res_temp_in = temp_ff;
               state_in    = ST_EMIT;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               temp_in = temp_ff + TEMP_STEP;
            end
         end
         ST_PICK: begin
            // Nearest step; a tie goes to the higher step.
            if (gap_lo < gap_hi) begin
               res_temp_in = temp_ff - TEMP_STEP;
            end else begin
               res_temp_in = temp_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = res_temp_ff;
               rsp_mv_in    = mv_ff;
               rsp_zero_in  = res_zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         reference_mv_ff  <= REFERENCE_MV_RESET;
         average_count_ff <= AVERAGE_COUNT_RESET;
         sensor_sum_ff    <= '0;
         reference_sum_ff <= '0;
         pair_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         reference_mv_ff  <= reference_mv_in;
         average_count_ff <= average_count_in;
         sensor_sum_ff    <= sensor_sum_in;
         reference_sum_ff <= reference_sum_in;
         pair_count_ff    <= pair_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      sensor_avg_ff <= sensor_avg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      divisor_ff    <= divisor_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      temp_ff       <= temp_in;
      mv_ff         <= mv_in;
      res_temp_ff   <= res_temp_in;
      res_zero_ff   <= res_zero_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

endmodule

`default_nettype wire

// ===== design/artl_checker.sv =====
// Port-level checker for the ADC ratio temperature lookup top level, bound to it below.
// Depends on artl_pkg for field widths and the temperature range.
`default_nettype none

module artl_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  artl_pkg::temp_type                  rsp_temperature_c,
   input  artl_pkg::mv_type                    rsp_sensor_mv,
   input  logic                                rsp_reference_zero
);
   import artl_pkg::*;

   localparam temp_type TEMP_MIN = TEMP_W'(T_LOW);
   localparam temp_type TEMP_MAX = TEMP_W'(T_LOW + T_STEP * (TABLE_ENTRIES - 1));

   // Reset leaves no result beat pending and the input side open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input closed after reset");

   // The input side closes only after it has taken a beat.
   a_ready_hold: assert property (@(posedge clock) disable iff (reset)
      (req_ready && !req_valid) |=> req_ready)
      else $error("input side closed without an accepted beat");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_sensor_mv) && $stable(rsp_temperature_c)
          && $stable(rsp_reference_zero)))
      else $error("result beat changed while stalled");

   // A zero reference average reports zero voltage and zero temperature.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reference_zero) |->
         (rsp_sensor_mv == '0 && rsp_temperature_c == '0))
      else $error("zero reference result carries nonzero fields");

   // A valid reading lies within the table's temperature span.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reference_zero) |->
         (rsp_temperature_c >= TEMP_MIN && rsp_temperature_c <= TEMP_MAX))
      else $error("temperature outside the table span");

endmodule

bind adc_ratio_temperature_lookup_top artl_checker u_artl_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_temperature_c  (rsp_temperature_c),
   .rsp_sensor_mv      (rsp_sensor_mv),
   .rsp_reference_zero (rsp_reference_zero)
);

`default_nettype wire
